[hdl/mfr_pkg.sv]
`timescale 1ns / 1ps

package mfr_pkg;

   // payload store size in bits and the counter that can hold it
   localparam int PAYLOAD_BITS = 2048;
   localparam int CNT_W        = $clog2(PAYLOAD_BITS + 1);

   // result queue between the edge front end and the output side
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // register indexes on the csr channel
   localparam logic [1:0] CSR_OWN_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT     = 2'd1;

   localparam logic [23:0] TIMEOUT_RESET = 24'd35000;

   // receive phases
   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_PRE_3   = 5'd3;
   localparam logic [4:0] PH_PRE_4   = 5'd4;
   localparam logic [4:0] PH_DEST    = 5'd5;
   localparam logic [4:0] PH_DEST_LS = 5'd12;
   localparam logic [4:0] PH_SRC     = 5'd13;
   localparam logic [4:0] PH_SRC_LS  = 5'd20;
   localparam logic [4:0] PH_TYPE    = 5'd21;
   localparam logic [4:0] PH_PAYLOAD = 5'd22;

   localparam logic [15:0] TRAILER_MARK = 16'h0001;
   localparam int          TRAILER_LEN  = 16;

   // floor(x / 3) == (x * RECIP3) >> 33 for every 32-bit x
   localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

   // window setup sequence after the preamble lock
   typedef enum logic [1:0] {
      SETUP_IDLE,
      SETUP_THIRD,
      SETUP_BOUNDS
   } setup_type;

   typedef struct packed {
      logic        payload_bit;
      logic [10:0] bit_index;
      logic        frame_end;
      logic        overflow;
      logic [7:0]  dest_address;
      logic [7:0]  source_address;
      logic        forward;
      logic        returned_home;
      logic        is_file;
   } res_type;

endpackage

[hdl/manchester_frame_receiver_core.sv]
`timescale 1ns / 1ps

// manchester frame receiver: decodes timestamped line edges into payload bits
// req channel: one line edge per request, tdata = {tick[31:0], level}
// rsp channel: one result per accepted payload bit; tlast marks the bit that
//   ends the frame by trailer, tuser carries is_file
// csr channel: index 0 own_address, index 1 timeout_us; csr_ready is always high
// results: each payload edge taken is registered into the result queue and shows on rsp from there
// throughput: one request per cycle while the result queue has room; after the
//   fifth preamble edge the front end holds req_tready low while the 32x32
//   reciprocal multiply forms period/3 and then the acceptance window bounds
// a four-entry result queue sits between the edge front end and rsp; a stalled
//   rsp consumer backs up into it, and req_tready drops only once it is full
// reset: phase back to waiting for preamble, all timing and address state
//   cleared, own_address 0, timeout_us 35000, result queue empty
module manchester_frame_receiver_core
   import mfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [0] level, [32:1] tick, [39:33] zero
   // response side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [0] payload_bit, [11:1] bit_index, [12] overflow,
                                    // [20:13] dest_address, [28:21] source_address,
                                    // [29] forward, [30] returned_home, [31] zero
   output logic        rsp_tlast,   // frame_end
   output logic        rsp_tuser,   // [0] is_file
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   logic    setup_busy;
   logic    q_full;
   logic    edge_accept;
   logic    res_push;
   res_type res_data;
   res_type out_data;

   // stall while the window is being set up or no result slot is free
   assign req_tready  = !setup_busy && !q_full;
   assign edge_accept = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;

   // front end: preamble lock, window check, header and payload tracking
   mfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .edge_accept (edge_accept),
      .edge_level  (req_tdata[0]),
      .edge_tick   (req_tdata[32:1]),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .setup_busy  (setup_busy),
      .res_push    (res_push),
      .res_data    (res_data)
   );

   // back end: result queue that drives the response channel
   mfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (q_full),
      .pop_ready (rsp_tready),
      .pop_valid (rsp_tvalid),
      .pop_data  (out_data)
   );

   assign rsp_tdata = {1'b0,
                       out_data.returned_home,
                       out_data.forward,
                       out_data.source_address,
                       out_data.dest_address,
                       out_data.overflow,
                       out_data.bit_index,
                       out_data.payload_bit};
   assign rsp_tlast = out_data.frame_end;
   assign rsp_tuser = out_data.is_file;

endmodule

[hdl/mfr_front.sv]
`timescale 1ns / 1ps

module mfr_front
   import mfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        edge_accept,
   input  logic        edge_level,
   input  logic [31:0] edge_tick,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data,
   output logic        setup_busy,
   output logic        res_push,
   output res_type     res_data
);

   logic [7:0]       own_ff, own_in;
   logic [23:0]      timeout_ff, timeout_in;
   logic [4:0]       phase_ff, phase_in;
   logic [31:0]      last_ff, last_in;
   logic [31:0]      second_ff, second_in;
   logic [31:0]      period_ff, period_in;
   logic [30:0]      third_ff, third_in;
   logic [31:0]      lo_ff, lo_in;
   logic [32:0]      hi_ff, hi_in;
   setup_type        setup_ff, setup_in;
   logic [7:0]       dest_ff, dest_in;
   logic [7:0]       src_ff, src_in;
   logic             fwd_ff, fwd_in;
   logic             home_ff, home_in;
   logic             file_ff, file_in;
   logic [15:0]      trail_ff, trail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [31:0]      gap;
   logic [63:0]      prod;
   logic             in_win;
   logic [7:0]       dest_next, src_next;
   logic [15:0]      trail_next;
   logic [CNT_W-1:0] count_next;
   logic             trailer, full;

   assign gap        = edge_tick - last_ff;
   assign prod       = 64'(period_ff) * 64'(RECIP3);
   assign in_win     = (gap >= lo_ff) && (33'(gap) <= hi_ff);
   assign dest_next  = {dest_ff[6:0], edge_level};
   assign src_next   = {src_ff[6:0], edge_level};
   assign trail_next = {trail_ff[14:0], edge_level};
   assign count_next = count_ff + CNT_W'(1);
   assign trailer    = (count_next >= CNT_W'(TRAILER_LEN)) && (trail_next == TRAILER_MARK);
   assign full       = (count_next >= CNT_W'(PAYLOAD_BITS));
   assign setup_busy = (setup_ff != SETUP_IDLE);

   always_comb begin
      own_in     = own_ff;
      timeout_in = timeout_ff;
      phase_in   = phase_ff;
      last_in    = last_ff;
      second_in  = second_ff;
      period_in  = period_ff;
      third_in   = third_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      setup_in   = setup_ff;
      dest_in    = dest_ff;
      src_in     = src_ff;
      fwd_in     = fwd_ff;
      home_in    = home_ff;
      file_in    = file_ff;
      trail_in   = trail_ff;
      count_in   = count_ff;
      res_push   = 1'b0;

      res_data.payload_bit    = edge_level;
      res_data.bit_index      = 11'(count_ff);
      res_data.frame_end      = trailer;
      res_data.overflow       = full && !trailer;
      res_data.dest_address   = dest_ff;
      res_data.source_address = src_ff;
      res_data.forward        = fwd_ff;
      res_data.returned_home  = home_ff;
      res_data.is_file        = file_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_OWN_ADDRESS: own_in     = csr_data[7:0];
            CSR_TIMEOUT:     timeout_in = csr_data;
            default:         ;
         endcase
      end

      // window bounds: period/3 by reciprocal, then the two bounds
      case (setup_ff)
         SETUP_THIRD: begin
            third_in = prod[63:33];
            setup_in = SETUP_BOUNDS;
         end
         SETUP_BOUNDS: begin
            lo_in    = period_ff - 32'(third_ff);
            hi_in    = 33'(period_ff) + 33'(third_ff);
            setup_in = SETUP_IDLE;
         end
         default: ;
      endcase

      if (edge_accept) begin
         if (phase_ff < PH_DEST) begin
            // preamble wants levels 1,0,1,0,1
            if (edge_level == ~phase_ff[0]) begin
               last_in = edge_tick;
               if (phase_ff == PH_IDLE) begin
                  phase_in = 5'd1;
               end else begin
                  if (phase_ff == PH_PRE_3) begin
                     second_in = gap;
                  end
                  if (phase_ff == PH_PRE_4) begin
                     period_in = 32'((33'(second_ff) + 33'(gap)) >> 1);
                     setup_in  = SETUP_THIRD;
                  end
                  phase_in = (gap > 32'(timeout_ff)) ? PH_IDLE : phase_ff + 5'd1;
               end
            end
         end else if (in_win) begin
            last_in = edge_tick;
            if (phase_ff < PH_SRC) begin
               dest_in  = dest_next;
               if (phase_ff == PH_DEST_LS) begin
                  fwd_in = (dest_next != own_ff);
               end
               phase_in = phase_ff + 5'd1;
            end else if (phase_ff < PH_TYPE) begin
               src_in = src_next;
               if (phase_ff == PH_SRC_LS) begin
                  home_in = (src_next == own_ff);
                  if (src_next == own_ff) begin
                     fwd_in = 1'b0;
                  end
               end
               phase_in = phase_ff + 5'd1;
            end else if (phase_ff == PH_TYPE) begin
               file_in  = ~edge_level;
               trail_in = '0;
               count_in = '0;
               phase_in = PH_PAYLOAD;
            end else begin
               res_push = 1'b1;
               if (trailer || full) begin
                  phase_in = PH_IDLE;
                  trail_in = '0;
                  count_in = '0;
               end else begin
                  trail_in = trail_next;
                  count_in = count_next;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff     <= '0;
         timeout_ff <= TIMEOUT_RESET;
         phase_ff   <= PH_IDLE;
         last_ff    <= '0;
         second_ff  <= '0;
         period_ff  <= '0;
         third_ff   <= '0;
         lo_ff      <= '0;
         hi_ff      <= '0;
         setup_ff   <= SETUP_IDLE;
         dest_ff    <= '0;
         src_ff     <= '0;
         fwd_ff     <= 1'b0;
         home_ff    <= 1'b0;
         file_ff    <= 1'b0;
         trail_ff   <= '0;
         count_ff   <= '0;
      end else begin
         own_ff     <= own_in;
         timeout_ff <= timeout_in;
         phase_ff   <= phase_in;
         last_ff    <= last_in;
         second_ff  <= second_in;
         period_ff  <= period_in;
         third_ff   <= third_in;
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         setup_ff   <= setup_in;
         dest_ff    <= dest_in;
         src_ff     <= src_in;
         fwd_ff     <= fwd_in;
         home_ff    <= home_in;
         file_ff    <= file_in;
         trail_ff   <= trail_in;
         count_ff   <= count_in;
      end
   end

   a_no_accept_in_setup: assert property (@(posedge clock) disable iff (reset)
      setup_busy |-> !edge_accept)
      else $error("edge taken while window setup runs");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_PAYLOAD)
      else $error("phase out of range");

   a_push_only_payload: assert property (@(posedge clock) disable iff (reset)
      res_push |-> (edge_accept && phase_ff == PH_PAYLOAD))
      else $error("result pushed outside payload phase");

   a_frame_end_idles: assert property (@(posedge clock) disable iff (reset)
      (res_push && (res_data.frame_end || res_data.overflow)) |=> phase_ff == PH_IDLE)
      else $error("frame end did not return to idle");

endmodule

[hdl/mfr_queue.sv]
`timescale 1ns / 1ps

module mfr_queue
   import mfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  res_type push_data,
   output logic    full,
   input  logic    pop_ready,
   output logic    pop_valid,
   output res_type pop_data
);

   res_type            slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ff, wr_in;
   logic [Q_PTR_W-1:0] rd_ff, rd_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;
   logic               pop;

   assign full      = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = slot_ff[rd_ff];
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      wr_in  = push ? wr_ff + Q_PTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + Q_PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("queue count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + Q_CNT_W'(1))
      else $error("queue count missed a push");

endmodule
